// ===== hw/rtl/cihm_pkg.sv =====
// Shared types and constants for the case-insensitive hash map.
// Holds op and status codes, FNV-1a constants, FSM state, command/status structs.
// No dependencies.
package cihm_pkg;

    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int KEY_MAX = 8;
    localparam int LEN_W   = 4;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic bad_op;
        logic hash_step;
        logic probe_start;
        logic mem_rd;
        logic probe_next;
        logic resolve;
        logic give_up;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic op_bad;
        logic hash_done;
        logic hit;
        logic probe_last;
        logic out_busy;
    } t_sts;

endpackage

// ===== hw/rtl/cihm_ctrl.sv =====
// Sequencer for the hash map: clear pass, hashing, probe loop, result hand-off.
// Depends on cihm_pkg for the state enum and command/status structs.
module cihm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cihm_pkg::t_sts i_sts,
    output cihm_pkg::t_cmd o_cmd
);
    import cihm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.op_bad ? S_FIN : S_HASH;
            end
            S_HASH: begin
                if (i_sts.hash_done) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit || i_sts.probe_last) n_state = S_FIN;
                else n_state = S_READ;
            end
            S_FIN: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                o_cmd.bad_op    = i_in_valid && i_sts.op_bad;
            end
            S_HASH: begin
                o_cmd.hash_step   = !i_sts.hash_done;
                o_cmd.probe_start = i_sts.hash_done;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
            end
            S_CMP: begin
                o_cmd.resolve    = i_sts.hit;
                o_cmd.give_up    = !i_sts.hit && i_sts.probe_last;
                o_cmd.probe_next = !i_sts.hit && !i_sts.probe_last;
            end
            S_FIN: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cihm_dp.sv =====
// Datapath for the hash map: key folding, serial FNV-1a, slot memory, probe
// counters and the result register. Depends on cihm_pkg.
module cihm_dp #(
    parameter int SLOTS     = 256,
    parameter int KEY_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_op,
    input  logic [cihm_pkg::KEY_W-1:0] i_key,
    input  logic [cihm_pkg::VAL_W-1:0] i_value,
    input  cihm_pkg::t_cmd             i_cmd,
    output cihm_pkg::t_sts             o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [cihm_pkg::VAL_W-1:0] o_value_out
);
    import cihm_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    t_entry r_mem [SLOTS];
    t_entry r_rd;

    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_canon;
    logic [VAL_W-1:0] r_value;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_byte_idx;
    logic [31:0]      r_hash;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] r_probe_idx;
    logic [IDX_W-1:0] r_probe_cnt;
    logic [1:0]       r_res_status;
    logic [VAL_W-1:0] r_res_vout;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [VAL_W-1:0] r_value_out;

    logic [KEY_W-1:0] n_canon;
    logic [LEN_W-1:0] n_len;
    logic [31:0]      n_hash;
    logic [7:0]       hash_byte;
    logic             hit;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic [1:0]       res_status;
    logic [VAL_W-1:0] res_vout;

    // Fold A-Z to lower case; bytes from the terminator (or past KEY_BYTES) are zero.
    always_comb begin
        logic       alive;
        logic [7:0] b;
        alive   = 1'b1;
        n_canon = '0;
        n_len   = '0;
        for (int i = 0; i < KEY_MAX; i++) begin
            b = i_key[8*i +: 8];
            if (i >= KEY_BYTES || b == 8'h00) alive = 1'b0;
            if (alive) begin
                n_canon[8*i +: 8] = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
                n_len             = LEN_W'(i + 1);
            end
        end
    end

    assign hash_byte = r_canon[8*r_byte_idx[2:0] +: 8];
    assign n_hash    = 32'((r_hash ^ {24'b0, hash_byte}) * FNV_PRIME);
    assign hit       = !r_rd.used || (r_rd.key == r_canon);

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_probe_idx;
        wr_data    = '0;
        res_status = ST_MISSING;
        res_vout   = '0;
        if (i_cmd.clear_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
        end else if (i_cmd.resolve) begin
            case (r_op)
                OP_SET: begin
                    wr_en      = 1'b1;
                    wr_data    = '{used: 1'b1, key: r_canon, value: r_value};
                    res_status = ST_OK;
                end
                OP_GET: begin
                    if (r_rd.used) begin
                        res_status = ST_OK;
                        res_vout   = r_rd.value;
                    end
                end
                OP_DEL: begin
                    if (r_rd.used) begin
                        wr_en      = 1'b1;
                        res_status = ST_OK;
                        res_vout   = r_rd.value;
                    end
                end
                default: begin
                    res_status = ST_MISSING;
                end
            endcase
        end else if (i_cmd.give_up) begin
            res_status = (r_op == OP_SET) ? ST_FULL : ST_MISSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.mem_rd) r_rd <= r_mem[r_probe_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op       <= i_op;
            r_canon    <= n_canon;
            r_value    <= i_value;
            r_len      <= n_len;
            r_byte_idx <= '0;
            r_hash     <= FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            r_hash     <= n_hash;
            r_byte_idx <= r_byte_idx + 1'b1;
        end
        if (i_cmd.probe_start) begin
            r_probe_idx <= r_hash[IDX_W-1:0];
            r_probe_cnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_probe_idx <= r_probe_idx + 1'b1;
            r_probe_cnt <= r_probe_cnt + 1'b1;
        end
        if (i_cmd.resolve || i_cmd.give_up || i_cmd.bad_op) begin
            r_res_status <= res_status;
            r_res_vout   <= res_vout;
        end
        if (i_cmd.out_load) begin
            r_status    <= r_res_status;
            r_value_out <= r_res_vout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_sts.clear_last = (r_clr_idx == IDX_LAST);
    assign o_sts.op_bad     = !(i_op == OP_SET || i_op == OP_GET || i_op == OP_DEL);
    assign o_sts.hash_done  = (r_byte_idx == r_len);
    assign o_sts.hit        = hit;
    assign o_sts.probe_last = (r_probe_cnt == IDX_LAST);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;

endmodule

// ===== hw/rtl/case_insensitive_hash_map.sv =====
// After the input transfer the key is hashed (one FNV-1a multiply per key byte),
// then slots are probed (one registered slot-memory read plus one compare each)
// until a free or matching slot or the last slot, and the result goes to the output
// register; an unused op goes straight to the result. The next item is taken once
// the result is in the output register, while it waits there. Reset: synchronous,
// active low; then a pass over every slot clears the slot memory, during which no item is taken.
module case_insensitive_hash_map #(
    parameter int SLOTS     = 256,
    parameter int KEY_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_op,
    input  logic [cihm_pkg::KEY_W-1:0] i_key,
    input  logic [cihm_pkg::VAL_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [cihm_pkg::VAL_W-1:0] o_value_out
);
    import cihm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cihm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cihm_dp #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_wr |-> !o_in_ready)
        else $error("input ready during clear pass");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear_wr, cmd.load_item, cmd.hash_step, cmd.mem_rd,
                  cmd.resolve, cmd.give_up, cmd.probe_next, cmd.out_load}))
        else $error("conflicting datapath commands");

    a_read_then_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_rd |=> (cmd.resolve || cmd.give_up || cmd.probe_next))
        else $error("slot read not followed by probe decision");
`endif

endmodule

// ===== tb/sv/case_insensitive_hash_map_tb.sv =====
// Self-checking testbench for case_insensitive_hash_map: directed and random set/get/delete
// traffic checked against a predictor of the FNV-1a, linear-probing key/value table.
// Depends on cihm_pkg and case_insensitive_hash_map.
`timescale 1ns / 1ps

module case_insensitive_hash_map_tb;
    import cihm_pkg::*;

    localparam int N_SLOTS     = 256;
    localparam int N_KEY_BYTES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int POOL_N       = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 6000000;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value;
    } t_reply;

    // Predicts one reply per accepted transfer and checks replies in order.
    class kv_table_model;
        bit               slot_used [N_SLOTS];
        logic [KEY_W-1:0] slot_key  [N_SLOTS];
        logic [VAL_W-1:0] slot_val  [N_SLOTS];
        int               n_used;
        int               n_errors;
        t_reply           replies [$];

        function new();
            n_used   = 0;
            n_errors = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        // Lower-case up to the terminator and hash the folded bytes.
        function logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw,
                                            output logic [31:0] h);
            logic [KEY_W-1:0] canon;
            logic [7:0]       b;
            bit               ended;
            canon = '0;
            h     = FNV_BASIS;
            ended = 1'b0;
            for (int i = 0; i < N_KEY_BYTES; i++) begin
                b = raw[8*i +: 8];
                if (b == 8'h00) ended = 1'b1;
                if (!ended) begin
                    if (b >= 8'h41 && b <= 8'h5A) b = b + 8'h20;
                    canon[8*i +: 8] = b;
                    h = (h ^ {24'h0, b}) * FNV_PRIME;
                end
            end
            return canon;
        endfunction

        function void note_input(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] val);
            logic [KEY_W-1:0] canon;
            logic [31:0]      h;
            int               idx;
            bit               hit;
            t_reply           r;
            canon    = fold_key(key, h);
            r.status = ST_MISSING;
            r.value  = '0;
            if (op != OP_UNUSED) begin
                hit = 1'b0;
                idx = int'(h & (N_SLOTS - 1));
                for (int n = 0; n < N_SLOTS && !hit; n++) begin
                    if (!slot_used[idx] || slot_key[idx] == canon) hit = 1'b1;
                    else idx = (idx + 1) % N_SLOTS;
                end
                if (op == OP_SET) begin
                    if (hit) begin
                        if (!slot_used[idx]) n_used++;
                        slot_used[idx] = 1'b1;
                        slot_key[idx]  = canon;
                        slot_val[idx]  = val;
                        r.status       = ST_OK;
                    end else begin
                        r.status = ST_FULL;
                    end
                end else if (hit && slot_used[idx]) begin
                    r.status = ST_OK;
                    r.value  = slot_val[idx];
                    if (op == OP_DEL) begin
                        slot_used[idx] = 1'b0;
                        n_used--;
                    end
                end
            end
            replies.push_back(r);
        endfunction

        function void check_reply(input logic [1:0] st, input logic [VAL_W-1:0] v);
            t_reply r;
            if (replies.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual status %0d value %h",
                         $time, st, v);
                return;
            end
            r = replies.pop_front();
            if (st !== r.status) begin
                n_errors++;
                $display("%0t: status mismatch, expected %0d actual %0d", $time, r.status, st);
            end
            if (v !== r.value) begin
                n_errors++;
                $display("%0t: value_out mismatch, expected %h actual %h", $time, r.value, v);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [1:0]       i_op;
    logic [KEY_W-1:0] i_key;
    logic [VAL_W-1:0] i_value;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [1:0]       o_status;
    logic [VAL_W-1:0] o_value_out;

    kv_table_model    model;
    logic [KEY_W-1:0] key_pool [POOL_N];
    bit               no_idle;
    int               hold_req;
    int               fill_n;

    case_insensitive_hash_map #(
        .SLOTS     (N_SLOTS),
        .KEY_BYTES (N_KEY_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
            5:             return 8'h30 + 8'($urandom_range(0, 9));
            6:             return 8'h80 + 8'($urandom_range(0, 127));
            7: begin
                // characters just outside the folding range
                case ($urandom_range(0, 3))
                    0:       return 8'h40;
                    1:       return 8'h5B;
                    2:       return 8'h60;
                    default: return 8'h7B;
                endcase
            end
            default:       return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] make_key(input int len);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < len; i++) k[8*i +: 8] = rand_byte();
        return k;
    endfunction

    // Random letter case, and sometimes junk after the terminator.
    function automatic logic [KEY_W-1:0] dress_key(input logic [KEY_W-1:0] base);
        logic [KEY_W-1:0] k;
        logic [7:0]       b;
        bit               ended;
        bit               junk;
        k     = base;
        ended = 1'b0;
        junk  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = k[8*i +: 8];
            if (!ended && b == 8'h00) begin
                ended = 1'b1;
                junk  = ($urandom_range(0, 3) == 0);
            end else if (ended) begin
                if (junk) k[8*i +: 8] = 8'($urandom);
            end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
                if ($urandom_range(0, 1)) k[8*i +: 8] = b ^ 8'h20;
            end
        end
        return k;
    endfunction

    // Distinct keys for filling the table: "F" plus index bytes that never fold.
    function automatic logic [KEY_W-1:0] fill_key(input int n);
        logic [KEY_W-1:0] k;
        k = '0;
        k[7:0]   = 8'h46;
        k[15:8]  = 8'h21 + 8'(n[3:0]);
        k[23:16] = 8'h21 + 8'(n[7:4]);
        k[31:24] = 8'h21 + 8'(n[9:8]);
        return k;
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transfer.
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= key;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic random_item(input bit loaded);
        int               r;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        r = $urandom_range(0, 99);
        if (loaded && $urandom_range(0, 1) && fill_n > 0)
            key = dress_key(fill_key($urandom_range(0, fill_n - 1)));
        else
            key = dress_key(key_pool[$urandom_range(0, POOL_N - 1)]);
        if (r < 3) begin
            send_item(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom);
        end else begin
            if (r < 5)                      op = OP_UNUSED;
            else if (r < (loaded ? 30 : 50)) op = OP_SET;
            else if (r < (loaded ? 60 : 80)) op = OP_GET;
            else                             op = OP_DEL;
            send_item(op, key, $urandom);
        end
    endtask

    // Transfer monitor: feeds the predictor and checks replies.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) model.note_input(i_op, i_key, i_value);
            if (o_out_valid && i_out_ready) model.check_reply(o_status, o_value_out);
        end
    end

    // Result side: short random stalls, calm stretches, and long holds on request.
    initial begin
        int hold_left;
        int hold_seen;
        int burst;
        int calm;
        hold_left   = 0;
        hold_seen   = 0;
        burst       = 0;
        calm        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_out_ready <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                i_out_ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 31) == 0) calm = $urandom_range(20, 80);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_op       = OP_SET;
        i_key      = '0;
        i_value    = '0;
        no_idle    = 1'b0;
        hold_req   = 0;
        fill_n     = 0;
        model      = new();
        foreach (key_pool[i]) key_pool[i] = make_key($urandom_range(0, 8));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty key, folding, junk past terminator, full-length key
        send_item(OP_SET, 64'h0, 32'hFFFF_FFFF);
        send_item(OP_GET, 64'h0, 32'h0);
        send_item(OP_SET, 64'h0000_0000_0043_4241, 32'h0);          // "ABC"
        send_item(OP_GET, 64'h0000_0000_0063_6261, 32'h0);          // "abc"
        send_item(OP_GET, 64'h005A_5958_0063_4261, 32'h0);          // "aBc" + junk
        send_item(OP_SET, 64'h524F_574F_4C4C_4548, 32'h1234_5678);  // "HELLOWOR"
        send_item(OP_GET, 64'h726F_576F_6C6C_6568, 32'h0);          // "helloWor"
        // high bytes are not folded
        send_item(OP_SET, 64'h0000_0000_0080_FFC1, 32'h5555_AAAA);
        send_item(OP_GET, 64'h0000_0000_0080_FFC1, 32'h0);
        send_item(OP_GET, 64'h0000_0000_0080_FFE1, 32'h0);
        // neighbors of the letter range
        send_item(OP_SET, 64'h0000_0000_7B60_5B40, 32'h0BAD_F00D);  // "@[`{"
        send_item(OP_GET, 64'h0000_0000_7B60_5B60, 32'h0);
        send_item(OP_SET, 64'h0000_0000_0000_5A41, 32'h0000_0001);  // "AZ"
        send_item(OP_GET, 64'h0000_0000_0000_7A61, 32'h0);          // "az"
        // overwrite, delete, delete again
        send_item(OP_SET, 64'h0000_0000_0063_6261, 32'hA5A5_A5A5);
        send_item(OP_GET, 64'h0000_0000_0043_4241, 32'h0);
        send_item(OP_DEL, 64'h0000_0000_0063_4241, 32'h0);
        send_item(OP_DEL, 64'h0000_0000_0063_6261, 32'h0);
        send_item(OP_GET, 64'h0000_0000_0063_6261, 32'h0);
        send_item(OP_UNUSED, 64'h0, 32'hFFFF_FFFF);
        send_item(OP_GET, 64'h0, 32'h0);
        send_item(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_item(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_item(OP_DEL, 64'h0, 32'h0);

        // light load
        for (int n = 0; n < 550; n++) begin
            if (n == 200) hold_req++;
            random_item(1'b0);
        end

        // fill every slot, then exercise the full table
        while (model.n_used < N_SLOTS && fill_n < 1024) begin
            send_item(OP_SET, dress_key(fill_key(fill_n)), $urandom);
            fill_n++;
        end
        send_item(OP_SET, fill_key(1023), 32'h1111_1111);
        send_item(OP_GET, fill_key(1023), 32'h0);
        send_item(OP_DEL, fill_key(1023), 32'h0);
        send_item(OP_UNUSED, fill_key(1023), 32'h0);
        send_item(OP_SET, fill_key(0), 32'h2222_2222);
        send_item(OP_GET, fill_key(0), 32'h0);
        send_item(OP_DEL, fill_key(1), 32'h0);
        send_item(OP_SET, fill_key(1022), 32'h3333_3333);
        send_item(OP_SET, fill_key(1021), 32'h4444_4444);

        // heavy load, draining; no idling in the last stretch
        for (int n = 0; n < 850; n++) begin
            if (n == 100) hold_req++;
            if (n == 650) no_idle = 1'b1;
            random_item(1'b1);
        end
        i_in_valid <= 1'b0;

        while (model.replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (model.n_errors == 0 && model.replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cihm_pkg.sv
hw/rtl/cihm_ctrl.sv
hw/rtl/cihm_dp.sv
hw/rtl/case_insensitive_hash_map.sv
tb/sv/case_insensitive_hash_map_tb.sv
